/* src/scab_pkg.sv */
// Shared constants, codes and control types for the segment slab clipper.
package scab_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int FRACTION_BITS = 16;
  localparam int TOL_WIDTH     = 16;
  localparam int CFG_IDX_W     = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BREAK_NEAR    = 3'd0,
    REG_BREAK_FAR     = 3'd1,
    REG_AXIS_IS_X     = 3'd2,
    REG_BREAK_ENABLED = 3'd3,
    REG_TOLERANCE     = 3'd4
  } cfg_idx_e;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_SAVE,
    OP_MUL,
    OP_FIN,
    OP_EMIT,
    OP_FINISH
  } op_e;

  // Interpolation jobs: half-parameter tests and crossing points
  typedef enum logic [2:0] {
    J_MID,
    J_LOH,
    J_LOX,
    J_LOY,
    J_HIH,
    J_HIX,
    J_HIY
  } job_e;

  // Kept piece shapes
  typedef enum logic [1:0] {
    P_WHOLE,
    P_LO,
    P_HI
  } piece_e;

  typedef struct packed {
    op_e    op;
    logic   lim_far;
    job_e   job;
    piece_e piece;
    logic   last;
    logic   none;
  } cmd_t;

  typedef struct packed {
    logic usable;
    logic hit_near;
    logic hit_far;
    logic lo_pos;
    logic hi_open;
    logic outside;
  } stat_t;

endpackage

/* src/scab_if.sv */
// Channel interfaces: segment input, piece output and configuration writes.
interface scab_seg_if #(
  parameter int CW = scab_pkg::COORD_WIDTH
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] start_x;
  logic [CW-1:0] start_y;
  logic [CW-1:0] end_x;
  logic [CW-1:0] end_y;
  logic          in_polyline;
  logic          last_of_curve;

  modport source (output valid, start_x, start_y, end_x, end_y, in_polyline, last_of_curve,
                  input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, in_polyline, last_of_curve,
                output ready);
endinterface

interface scab_piece_if #(
  parameter int CW = scab_pkg::COORD_WIDTH
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] piece_start_x;
  logic [CW-1:0] piece_start_y;
  logic [CW-1:0] piece_end_x;
  logic [CW-1:0] piece_end_y;
  logic          joins_run;
  logic          last_piece;

  modport source (output valid, piece_start_x, piece_start_y, piece_end_x, piece_end_y,
                  joins_run, last_piece, input ready);
  modport sink (input valid, piece_start_x, piece_start_y, piece_end_x, piece_end_y,
                joins_run, last_piece, output ready);
endinterface

interface scab_cfg_if #(
  parameter int CW = scab_pkg::COORD_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic [scab_pkg::CFG_IDX_W-1:0] index;
  logic [CW-1:0]                  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/scab_datapath.sv */
// Datapath: config registers, segment registers, serial divider, lerp unit, run tracking.
module scab_datapath #(
  parameter int CW = scab_pkg::COORD_WIDTH,
  parameter int FB = scab_pkg::FRACTION_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [scab_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CW-1:0]                  cfg_data_i,
  input  logic [CW-1:0]                  start_x_i,
  input  logic [CW-1:0]                  start_y_i,
  input  logic [CW-1:0]                  end_x_i,
  input  logic [CW-1:0]                  end_y_i,
  input  logic                           in_polyline_i,
  input  logic                           last_of_curve_i,
  input  scab_pkg::cmd_t                 cmd_i,
  output scab_pkg::stat_t                stat_o,
  output logic [CW-1:0]                  piece_start_x_o,
  output logic [CW-1:0]                  piece_start_y_o,
  output logic [CW-1:0]                  piece_end_x_o,
  output logic [CW-1:0]                  piece_end_y_o,
  output logic                           joins_run_o,
  output logic                           last_piece_o
);

  localparam int DW = CW + 1;
  localparam int TW = FB + 1;
  localparam int PW = DW + TW;
  localparam int TOLW = scab_pkg::TOL_WIDTH;
  localparam logic [TW-1:0] ONE_T  = {1'b1, {FB{1'b0}}};
  localparam logic [TW-1:0] HALF_T = ONE_T >> 1;

  // configuration
  logic [CW-1:0]   near_q, far_q;
  logic            axis_x_q, enabled_q;
  logic [TOLW-1:0] tol_q;

  // segment
  logic [CW-1:0] ax_q, ay_q, bx_q, by_q;
  logic          poly_q, last_q;

  // divider
  logic [PW-1:0] rem_q, dsh_q;
  logic [TW-1:0] quo_q;
  logic [TW-1:0] tn_q, tf_q;

  // lerp unit
  logic [PW-1:0] prod_q;
  logic          neg_q;
  logic [CW-1:0] base_q;
  logic [CW-1:0] mid_q, lox_q, loy_q, hix_q, hiy_q;

  // run tracking
  logic          run_open_q;
  logic [CW-1:0] run_end_q;

  function automatic logic signed [DW-1:0] sext(input logic [CW-1:0] v);
    return $signed({v[CW-1], v});
  endfunction

  function automatic logic cross_hit(input logic signed [DW-1:0] f, input logic signed [DW-1:0] t,
                                     input logic signed [DW-1:0] lim, input logic [DW-1:0] tol);
    logic [DW-1:0] den;
    logic          up;
    up  = t > f;
    den = up ? DW'(t - f) : DW'(f - t);
    return (den != '0) && (den >= tol) && (up ? (lim > f && lim < t) : (lim < f && lim > t));
  endfunction

  logic signed [DW-1:0] fa_w, ta_w, near_w, far_w, lim_w, tol_w, mid_w;
  logic [DW-1:0]        den_w, num_w;
  logic                 hn, hf;
  logic [TW-1:0]        lo_t, hi_t, quo_c;
  logic [TW:0]          hih_sum;
  logic [CW-1:0]        la, lb;
  logic [TW-1:0]        lt;
  logic signed [DW-1:0] ldiff;
  logic [DW-1:0]        lmag;
  logic [PW-1:0]        rsum;
  logic [CW-1:0]        rnd, lres;
  logic                 rem_ge;
  logic [CW-1:0]        ps_x, ps_y, pe_x, pe_y, s_al, e_al;
  logic signed [DW-1:0] gap_d;
  logic [DW-1:0]        gap;

  // along-axis view and crossing tests
  always_comb begin
    fa_w   = axis_x_q ? sext(ax_q) : sext(ay_q);
    ta_w   = axis_x_q ? sext(bx_q) : sext(by_q);
    near_w = sext(near_q);
    far_w  = sext(far_q);
    tol_w  = $signed({{(DW-TOLW){1'b0}}, tol_q});
    mid_w  = sext(mid_q);
    hn     = cross_hit(fa_w, ta_w, near_w, tol_w);
    hf     = cross_hit(fa_w, ta_w, far_w, tol_w);
    lim_w  = cmd_i.lim_far ? far_w : near_w;
    den_w  = (ta_w > fa_w) ? DW'(ta_w - fa_w) : DW'(fa_w - ta_w);
    num_w  = (ta_w > fa_w) ? DW'(lim_w - fa_w) : DW'(fa_w - lim_w);
  end

  // cut parameters of the kept parts
  always_comb begin
    if (!hn) begin
      lo_t = '0;
    end else if (hf) begin
      lo_t = (tn_q < tf_q) ? tn_q : tf_q;
    end else begin
      lo_t = tn_q;
    end
    if (!hf) begin
      hi_t = ONE_T;
    end else if (hn) begin
      hi_t = (tn_q > tf_q) ? tn_q : tf_q;
    end else begin
      hi_t = tf_q;
    end
    hih_sum = {1'b0, hi_t} + {1'b0, ONE_T};
    quo_c   = (quo_q > ONE_T) ? ONE_T : quo_q;
    rem_ge  = rem_q >= dsh_q;
  end

  always_comb begin
    stat_o.usable   = enabled_q && ((far_w - near_w) > tol_w);
    stat_o.hit_near = hn;
    stat_o.hit_far  = hf;
    stat_o.lo_pos   = lo_t != '0;
    stat_o.hi_open  = hi_t < ONE_T;
    stat_o.outside  = ((mid_w - near_w) <= tol_w) || ((far_w - mid_w) <= tol_w);
  end

  // lerp operand selection by job
  always_comb begin
    la = axis_x_q ? ax_q : ay_q;
    lb = axis_x_q ? bx_q : by_q;
    lt = HALF_T;
    unique case (cmd_i.job)
      scab_pkg::J_MID: lt = HALF_T;
      scab_pkg::J_LOH: lt = lo_t >> 1;
      scab_pkg::J_LOX: begin
        la = ax_q; lb = bx_q; lt = lo_t;
      end
      scab_pkg::J_LOY: begin
        la = ay_q; lb = by_q; lt = lo_t;
      end
      scab_pkg::J_HIH: lt = hih_sum[TW:1];
      scab_pkg::J_HIX: begin
        la = ax_q; lb = bx_q; lt = hi_t;
      end
      scab_pkg::J_HIY: begin
        la = ay_q; lb = by_q; lt = hi_t;
      end
      default: lt = HALF_T;
    endcase
    ldiff = sext(lb) - sext(la);
    lmag  = ldiff[DW-1] ? DW'(-ldiff) : DW'(ldiff);
    rsum  = prod_q + {{DW{1'b0}}, HALF_T};
    rnd   = rsum[FB +: CW];
    lres  = neg_q ? (base_q - rnd) : (base_q + rnd);
  end

  // piece selection for output
  always_comb begin
    ps_x = ax_q; ps_y = ay_q; pe_x = bx_q; pe_y = by_q;
    unique case (cmd_i.piece)
      scab_pkg::P_WHOLE: ;
      scab_pkg::P_LO: begin
        pe_x = lox_q; pe_y = loy_q;
      end
      scab_pkg::P_HI: begin
        ps_x = hix_q; ps_y = hiy_q;
      end
      default: ;
    endcase
    s_al  = axis_x_q ? ps_x : ps_y;
    e_al  = axis_x_q ? pe_x : pe_y;
    gap_d = sext(s_al) - sext(run_end_q);
    gap   = gap_d[DW-1] ? DW'(-gap_d) : DW'(gap_d);
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q    <= '0;
      far_q     <= '0;
      axis_x_q  <= 1'b1;
      enabled_q <= 1'b0;
      tol_q     <= TOLW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        scab_pkg::REG_BREAK_NEAR:    near_q    <= cfg_data_i;
        scab_pkg::REG_BREAK_FAR:     far_q     <= cfg_data_i;
        scab_pkg::REG_AXIS_IS_X:     axis_x_q  <= cfg_data_i[0];
        scab_pkg::REG_BREAK_ENABLED: enabled_q <= cfg_data_i[0];
        scab_pkg::REG_TOLERANCE:     tol_q     <= cfg_data_i[TOLW-1:0];
        default: ;
      endcase
    end
  end

  // run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q <= 1'b0;
      run_end_q  <= '0;
    end else if (cmd_i.op == scab_pkg::OP_EMIT && poly_q) begin
      run_open_q <= 1'b1;
      run_end_q  <= e_al;
    end else if (cmd_i.op == scab_pkg::OP_FINISH && (!poly_q || last_q || cmd_i.none)) begin
      run_open_q <= 1'b0;
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      scab_pkg::OP_LOAD: begin
        ax_q   <= start_x_i;
        ay_q   <= start_y_i;
        bx_q   <= end_x_i;
        by_q   <= end_y_i;
        poly_q <= in_polyline_i;
        last_q <= last_of_curve_i;
      end
      scab_pkg::OP_DIV_INIT: begin
        rem_q <= {1'b0, num_w, {FB{1'b0}}} + {{TW{1'b0}}, den_w >> 1};
        dsh_q <= {1'b0, den_w, {FB{1'b0}}};
        quo_q <= '0;
      end
      scab_pkg::OP_DIV_STEP: begin
        if (rem_ge) begin
          rem_q <= rem_q - dsh_q;
        end
        dsh_q <= dsh_q >> 1;
        quo_q <= {quo_q[TW-2:0], rem_ge};
      end
      scab_pkg::OP_DIV_SAVE: begin
        if (cmd_i.lim_far) begin
          tf_q <= quo_c;
        end else begin
          tn_q <= quo_c;
        end
      end
      scab_pkg::OP_MUL: begin
        prod_q <= lmag * lt;
        neg_q  <= ldiff[DW-1];
        base_q <= la;
      end
      scab_pkg::OP_FIN: begin
        unique case (cmd_i.job)
          scab_pkg::J_LOX: lox_q <= lres;
          scab_pkg::J_LOY: loy_q <= lres;
          scab_pkg::J_HIX: hix_q <= lres;
          scab_pkg::J_HIY: hiy_q <= lres;
          default:         mid_q <= lres;
        endcase
      end
      scab_pkg::OP_EMIT: begin
        piece_start_x_o <= ps_x;
        piece_start_y_o <= ps_y;
        piece_end_x_o   <= pe_x;
        piece_end_y_o   <= pe_y;
        joins_run_o     <= poly_q && run_open_q && (gap <= DW'(tol_q));
        last_piece_o    <= cmd_i.last;
      end
      default: ;
    endcase
  end

endmodule

/* src/scab_ctrl.sv */
// Controller: sequences load, divisions, interpolations and piece beats.
module scab_ctrl #(
  parameter int FB = scab_pkg::FRACTION_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  scab_pkg::stat_t stat_i,
  output scab_pkg::cmd_t  cmd_o
);

  localparam int TW   = FB + 1;
  localparam int CNTW = $clog2(TW);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_INIT,
    S_DIV_RUN,
    S_DIV_SAVE,
    S_ROUTE,
    S_MUL,
    S_FIN,
    S_PLAN,
    S_EMIT,
    S_OUT,
    S_FINISH
  } state_e;

  state_e            state_q;
  logic [CNTW-1:0]   cnt_q;
  logic              far_q;
  scab_pkg::job_e    job_q;
  scab_pkg::piece_e  piece_q;
  logic              keep_whole_q, keep_a_q, keep_b_q, out_valid_q;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  // datapath command for the current state
  always_comb begin
    cmd_o.op      = scab_pkg::OP_IDLE;
    cmd_o.lim_far = far_q;
    cmd_o.job     = job_q;
    cmd_o.piece   = piece_q;
    cmd_o.last    = !(piece_q == scab_pkg::P_LO && keep_b_q);
    cmd_o.none    = !(keep_whole_q || keep_a_q || keep_b_q);
    unique case (state_q)
      S_IDLE:     cmd_o.op = in_valid_i ? scab_pkg::OP_LOAD : scab_pkg::OP_IDLE;
      S_DIV_INIT: cmd_o.op = scab_pkg::OP_DIV_INIT;
      S_DIV_RUN:  cmd_o.op = scab_pkg::OP_DIV_STEP;
      S_DIV_SAVE: cmd_o.op = scab_pkg::OP_DIV_SAVE;
      S_MUL:      cmd_o.op = scab_pkg::OP_MUL;
      S_FIN:      cmd_o.op = scab_pkg::OP_FIN;
      S_EMIT:     cmd_o.op = scab_pkg::OP_EMIT;
      S_FINISH:   cmd_o.op = scab_pkg::OP_FINISH;
      default:    cmd_o.op = scab_pkg::OP_IDLE;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      far_q        <= 1'b0;
      job_q        <= scab_pkg::J_MID;
      piece_q      <= scab_pkg::P_WHOLE;
      keep_whole_q <= 1'b0;
      keep_a_q     <= 1'b0;
      keep_b_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            keep_whole_q <= 1'b0;
            keep_a_q     <= 1'b0;
            keep_b_q     <= 1'b0;
            state_q      <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!stat_i.usable) begin
            keep_whole_q <= 1'b1;
            piece_q      <= scab_pkg::P_WHOLE;
            state_q      <= S_EMIT;
          end else if (stat_i.hit_near) begin
            far_q   <= 1'b0;
            state_q <= S_DIV_INIT;
          end else if (stat_i.hit_far) begin
            far_q   <= 1'b1;
            state_q <= S_DIV_INIT;
          end else begin
            job_q   <= scab_pkg::J_MID;
            state_q <= S_MUL;
          end
        end
        S_DIV_INIT: begin
          cnt_q   <= '0;
          state_q <= S_DIV_RUN;
        end
        S_DIV_RUN: begin
          cnt_q <= cnt_q + CNTW'(1);
          if (cnt_q == CNTW'(TW - 1)) begin
            state_q <= S_DIV_SAVE;
          end
        end
        S_DIV_SAVE: begin
          if (!far_q && stat_i.hit_far) begin
            far_q   <= 1'b1;
            state_q <= S_DIV_INIT;
          end else begin
            state_q <= S_ROUTE;
          end
        end
        S_ROUTE: begin
          if (stat_i.lo_pos) begin
            job_q   <= scab_pkg::J_LOH;
            state_q <= S_MUL;
          end else if (stat_i.hi_open) begin
            job_q   <= scab_pkg::J_HIH;
            state_q <= S_MUL;
          end else begin
            state_q <= S_FINISH;
          end
        end
        S_MUL: state_q <= S_FIN;
        S_FIN: state_q <= S_PLAN;
        S_PLAN: begin
          unique case (job_q)
            scab_pkg::J_MID: begin
              if (stat_i.outside) begin
                keep_whole_q <= 1'b1;
                piece_q      <= scab_pkg::P_WHOLE;
                state_q      <= S_EMIT;
              end else begin
                state_q <= S_FINISH;
              end
            end
            scab_pkg::J_LOH: begin
              if (stat_i.outside) begin
                keep_a_q <= 1'b1;
                job_q    <= scab_pkg::J_LOX;
                state_q  <= S_MUL;
              end else if (stat_i.hi_open) begin
                job_q   <= scab_pkg::J_HIH;
                state_q <= S_MUL;
              end else begin
                state_q <= S_FINISH;
              end
            end
            scab_pkg::J_LOX: begin
              job_q   <= scab_pkg::J_LOY;
              state_q <= S_MUL;
            end
            scab_pkg::J_LOY: begin
              if (stat_i.hi_open) begin
                job_q   <= scab_pkg::J_HIH;
                state_q <= S_MUL;
              end else begin
                piece_q <= scab_pkg::P_LO;
                state_q <= S_EMIT;
              end
            end
            scab_pkg::J_HIH: begin
              if (stat_i.outside) begin
                keep_b_q <= 1'b1;
                job_q    <= scab_pkg::J_HIX;
                state_q  <= S_MUL;
              end else if (keep_a_q) begin
                piece_q <= scab_pkg::P_LO;
                state_q <= S_EMIT;
              end else begin
                state_q <= S_FINISH;
              end
            end
            scab_pkg::J_HIX: begin
              job_q   <= scab_pkg::J_HIY;
              state_q <= S_MUL;
            end
            scab_pkg::J_HIY: begin
              piece_q <= keep_a_q ? scab_pkg::P_LO : scab_pkg::P_HI;
              state_q <= S_EMIT;
            end
            default: state_q <= S_FINISH;
          endcase
        end
        S_EMIT: begin
          out_valid_q <= 1'b1;
          state_q     <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (piece_q == scab_pkg::P_LO && keep_b_q) begin
              piece_q <= scab_pkg::P_HI;
              state_q <= S_EMIT;
            end else begin
              state_q <= S_FINISH;
            end
          end
        end
        S_FINISH: state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result beat is offered only while waiting on the output
  a_out_in_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == S_OUT)
    else $error("piece valid outside output wait");

  // a whole-segment piece never mixes with cut pieces
  a_whole_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    keep_whole_q |-> !keep_a_q && !keep_b_q)
    else $error("whole and cut pieces both kept");

  // a new segment is only taken with no pending piece
  a_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_q && state_q == S_CHECK)
    else $error("segment accepted while busy");

  // the high piece is emitted only when it was kept
  a_hi_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && piece_q == scab_pkg::P_HI) |-> keep_b_q)
    else $error("high piece emitted without being kept");
`endif

endmodule

/* src/segment_clip_against_break_slab.sv */
// Segment clipper against a break slab along x or y, Q1.16 crossing parameters.
// Processing: one segment at a time, through the serial divider (FRACTION_BITS+1 steps per
//   crossing) and the shared interpolation unit, plus stalls on the piece output.
// Reset: asynchronous active low; limits 0, axis x, break disabled, tolerance 1, run closed.
module segment_clip_against_break_slab #(
  parameter int COORD_WIDTH   = scab_pkg::COORD_WIDTH,
  parameter int FRACTION_BITS = scab_pkg::FRACTION_BITS
) (
  input logic          clk_i,
  input logic          rst_ni,
  scab_cfg_if.sink     cfg_i,
  scab_seg_if.sink     seg_i,
  scab_piece_if.source piece_o
);

  scab_pkg::cmd_t  cmd;
  scab_pkg::stat_t stat;

  assign cfg_i.ready = 1'b1;

  scab_ctrl #(
    .FB (FRACTION_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (seg_i.valid),
    .in_ready_o  (seg_i.ready),
    .out_valid_o (piece_o.valid),
    .out_ready_i (piece_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  scab_datapath #(
    .CW (COORD_WIDTH),
    .FB (FRACTION_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .start_x_i       (seg_i.start_x),
    .start_y_i       (seg_i.start_y),
    .end_x_i         (seg_i.end_x),
    .end_y_i         (seg_i.end_y),
    .in_polyline_i   (seg_i.in_polyline),
    .last_of_curve_i (seg_i.last_of_curve),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .piece_start_x_o (piece_o.piece_start_x),
    .piece_start_y_o (piece_o.piece_start_y),
    .piece_end_x_o   (piece_o.piece_end_x),
    .piece_end_y_o   (piece_o.piece_end_y),
    .joins_run_o     (piece_o.joins_run),
    .last_piece_o    (piece_o.last_piece)
  );

endmodule
